// ===== sv/spi_pkg.sv =====
package spi_pkg;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_TICK    = 2'd1,
    OP_RESTART = 2'd2,
    OP_NONE    = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    UOP_SQRT = 2'd0,
    UOP_DIV  = 2'd1
  } unit_op_t;

  // Request to the shared root/divide unit.
  typedef struct packed {
    logic     start;
    unit_op_t op;
  } unit_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_L_SQ0,
    ST_L_SQ1,
    ST_L_SQ2,
    ST_L_ROOT,
    ST_L_ROOTW,
    ST_L_TDIV,
    ST_L_TDIVW,
    ST_L_RDIV,
    ST_L_RDIVW,
    ST_L_WRITE,
    ST_T_READ,
    ST_T_WAIT,
    ST_T_CHECK,
    ST_T_FDIV,
    ST_T_FDIVW,
    ST_T_MUL,
    ST_T_MULW,
    ST_T_OUT,
    ST_OUT
  } state_t;

endpackage

// ===== sv/spi_ram.sv =====
module spi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/spi_unit.sv =====
// Shared bit-serial unit: 64-bit integer square root (one result bit per cycle)
// and 96/64 restoring division producing a 96-bit quotient, one bit per cycle.
module spi_unit (
  input  logic                clk,
  input  logic                rst,
  input  spi_pkg::unit_req_t  req,
  input  logic [95:0]         num,
  input  logic [63:0]         den,
  output spi_pkg::unit_stat_t stat,
  output logic [95:0]         result
);
  import spi_pkg::*;

  unit_op_t    op;
  logic [6:0]  cnt;
  logic        busy;
  logic [95:0] quo;
  logic [64:0] rem;
  logic [63:0] dv;
  logic [63:0] sq_v;
  logic [31:0] sq_r;
  logic [64:0] rem_sh;
  logic [63:0] sq_try;
  logic [31:0] sq_cand;
  logic        done;

  always_comb begin
    rem_sh  = {rem[63:0], quo[95]};
    sq_cand = sq_r | (32'd1 << cnt[4:0]);
    sq_try  = {32'd0, sq_cand} * {32'd0, sq_cand};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      op   <= UOP_SQRT;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        op   <= req.op;
        if (req.op == UOP_SQRT) begin
          cnt  <= 7'd31;
          sq_v <= num[63:0];
          sq_r <= '0;
        end else begin
          cnt <= 7'd95;
          quo <= num;
          rem <= '0;
          dv  <= den;
        end
      end else if (busy) begin
        if (op == UOP_SQRT) begin
          if (sq_try <= sq_v) begin
            sq_r <= sq_cand;
          end
        end else begin
          if (rem_sh >= {1'b0, dv}) begin
            rem <= rem_sh - {1'b0, dv};
            quo <= {quo[94:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[94:0], 1'b0};
          end
        end
        if (cnt == 7'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 7'd1;
        end
      end
    end
  end

  assign result    = (op == UOP_SQRT) ? {64'd0, sq_r} : quo;
  assign stat.busy = busy;
  assign stat.done = done;
endmodule

// ===== sv/segment_path_interpolator.sv =====
// Piecewise-linear motion path player. A load (opcode 0) stores a segment's
// translation and rotation and computes its duration on a shared bit-serial
// unit: a square root of the squared translation length and two 96-bit
// divides. A tick (opcode 1) adds delta_time to the segment time, walks over
// every finished segment (one table read each), then divides once for the
// fraction and scales the six components on one multiplier. A restart
// (opcode 2) clears the segment time, the active segment and the totals.
// The block accepts no new item until the current one is done and its
// result, if any, has been taken. Ticks after the table is exhausted give
// one result with done_res set; later ticks give nothing until a restart.
module segment_path_interpolator #(
  parameter int MAX_SEGMENTS = 64,
  parameter int FRAC_BITS    = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [6:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         opcode,
  input  logic [5:0]         segment_index,
  input  logic signed [31:0] move_x,
  input  logic signed [31:0] move_y,
  input  logic signed [31:0] move_z,
  input  logic signed [31:0] turn_x,
  input  logic signed [31:0] turn_y,
  input  logic signed [31:0] turn_z,
  input  logic [31:0]        move_speed,
  input  logic [31:0]        turn_speed,
  input  logic [31:0]        delta_time,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  output logic signed [31:0] angle_x,
  output logic signed [31:0] angle_y,
  output logic signed [31:0] angle_z,
  output logic               done_res
);
  import spi_pkg::*;

  localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);

  state_t state, state_next;

  logic [6:0]   segment_count;
  logic [31:0]  segment_elapsed;
  logic [CW-1:0] active_segment;
  logic [31:0]  tot [6];
  logic         running_flag;

  // Latched item.
  logic [31:0]  vec [6];
  logic [31:0]  mspd, tspd;
  logic [AW-1:0] widx;
  logic         wok;

  logic [63:0]  sq;
  logic [31:0]  amax;
  logic [95:0]  tdur;
  logic [63:0]  frac;
  logic [2:0]   lane;
  logic [63:0]  prod;
  logic [31:0]  res [6];

  // Shared unit.
  unit_req_t  req;
  unit_stat_t ust;
  logic [95:0] unum, ures;
  logic [63:0] uden;

  spi_unit u_unit (
    .clk(clk), .rst(rst), .req(req), .num(unum), .den(uden),
    .stat(ust), .result(ures)
  );

  // Segment table: 192 bits of vectors plus 32 bits of duration per entry.
  logic          t_we;
  logic [AW-1:0] t_raddr;
  logic [223:0]  t_wdata, t_rdata;
  logic [31:0]   cur_dur;

  spi_ram #(.WIDTH(224), .DEPTH(MAX_SEGMENTS)) u_table (
    .clk(clk), .we(t_we), .waddr(widx), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_rdata)
  );

  logic [CW-1:0] eff_count;
  logic [31:0]   abs_v [6];
  logic [63:0]   sq_term;
  logic [31:0]   cmax;
  logic [95:0]   dmax;
  logic [32:0]   esum;
  logic          accept;

  // Rotation term lands in the unit result; a zero speed forces zero.
  // The write stage compares it against the translation term while the
  // divider output is still held.
  logic [95:0] rdur_eff;
  assign rdur_eff = (tspd == '0) ? '0 : ures;

  assign accept  = in_valid && !in_stall;
  assign cur_dur = t_rdata[31:0];

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      abs_v[i] = vec[i][31] ? (32'd0 - vec[i]) : vec[i];
    end
    cmax = amax;
    for (int i = 3; i < 6; i++) begin
      if (abs_v[i] > cmax) cmax = abs_v[i];
    end
    case (state)
      ST_L_SQ1: sq_term = abs_v[1] * abs_v[1];
      ST_L_SQ2: sq_term = abs_v[2] * abs_v[2];
      default:  sq_term = abs_v[0] * abs_v[0];
    endcase
    dmax = (rdur_eff > tdur) ? rdur_eff : tdur;
    esum = {1'b0, segment_elapsed} + {1'b0, delta_time};
    if ({25'd0, segment_count} > MAX_SEGMENTS) begin
      eff_count = CW'(MAX_SEGMENTS);
    end else begin
      eff_count = CW'(segment_count);
    end
  end

  assign t_wdata = {vec[0], vec[1], vec[2], vec[3], vec[4], vec[5],
                    (dmax > 96'hFFFFFFFF) ? 32'hFFFFFFFF : dmax[31:0]};
  assign t_raddr = active_segment[AW-1:0];

  // Multiplier input: signed vector times fraction, truncated toward zero.
  logic signed [64:0] sprod;
  logic signed [32:0] fr_s;
  assign fr_s  = {1'b0, frac[31:0]};
  always_comb begin
    case (lane)
      3'd0: sprod = $signed(t_rdata[223:192]) * fr_s;
      3'd1: sprod = $signed(t_rdata[191:160]) * fr_s;
      3'd2: sprod = $signed(t_rdata[159:128]) * fr_s;
      3'd3: sprod = $signed(t_rdata[127:96]) * fr_s;
      3'd4: sprod = $signed(t_rdata[95:64]) * fr_s;
      default: sprod = $signed(t_rdata[63:32]) * fr_s;
    endcase
  end
  logic [63:0] pmag, shq;
  assign pmag = prod[63] ? (64'd0 - prod) : prod;
  assign shq  = prod[63] ? (64'd0 - (pmag >> FRAC_BITS)) : (pmag >> FRAC_BITS);

  always_comb begin
    state_next = state;
    req.start  = 1'b0;
    req.op     = UOP_SQRT;
    unum       = '0;
    uden       = '0;
    t_we       = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (opcode_t'(opcode))
            OP_LOAD:  state_next = ST_L_SQ0;
            OP_TICK:  state_next = running_flag ? ST_T_READ : ST_IDLE;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_L_SQ0: state_next = ST_L_SQ1;
      ST_L_SQ1: state_next = ST_L_SQ2;
      ST_L_SQ2: state_next = ST_L_ROOT;
      ST_L_ROOT: begin
        req.start  = 1'b1;
        unum       = {32'd0, sq};
        state_next = ST_L_ROOTW;
      end
      ST_L_ROOTW: if (ust.done) state_next = ST_L_TDIV;
      ST_L_TDIV: begin
        req.start  = 1'b1;
        req.op     = UOP_DIV;
        unum       = {32'd0, ures[63:0]} << FRAC_BITS;
        uden       = {32'd0, mspd};
        state_next = ST_L_TDIVW;
      end
      ST_L_TDIVW: if (ust.done) state_next = ST_L_RDIV;
      ST_L_RDIV: begin
        req.start  = 1'b1;
        req.op     = UOP_DIV;
        unum       = {64'd0, amax} << FRAC_BITS;
        uden       = {32'd0, tspd};
        state_next = ST_L_RDIVW;
      end
      ST_L_RDIVW: if (ust.done) state_next = ST_L_WRITE;
      ST_L_WRITE: begin
        t_we       = wok;
        state_next = ST_IDLE;
      end
      ST_T_READ:  state_next = ST_T_WAIT;
      ST_T_WAIT:  state_next = ST_T_CHECK;
      ST_T_CHECK: begin
        if (active_segment >= eff_count) begin
          state_next = ST_OUT;
        end else if (segment_elapsed >= cur_dur) begin
          state_next = ST_T_WAIT;
        end else begin
          state_next = ST_T_FDIV;
        end
      end
      ST_T_FDIV: begin
        req.start  = 1'b1;
        req.op     = UOP_DIV;
        unum       = {64'd0, segment_elapsed} << FRAC_BITS;
        uden       = {32'd0, cur_dur};
        state_next = ST_T_FDIVW;
      end
      ST_T_FDIVW: if (ust.done) state_next = ST_T_MUL;
      ST_T_MUL:   state_next = ST_T_MULW;
      ST_T_MULW:  state_next = (lane == 3'd5) ? ST_T_OUT : ST_T_MUL;
      ST_T_OUT:   state_next = ST_OUT;
      ST_OUT:     if (!out_stall) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_count   <= '0;
      segment_elapsed <= '0;
      active_segment  <= '0;
      running_flag    <= 1'b1;
      done_res        <= 1'b0;
      for (int i = 0; i < 6; i++) tot[i] <= '0;
    end else begin
      if (cfg_we) segment_count <= cfg_wdata;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            vec[0] <= move_x; vec[1] <= move_y; vec[2] <= move_z;
            vec[3] <= turn_x; vec[4] <= turn_y; vec[5] <= turn_z;
            mspd   <= move_speed;
            tspd   <= turn_speed;
            widx   <= AW'(segment_index);
            wok    <= ({26'd0, segment_index} < MAX_SEGMENTS);
            sq     <= '0;
            amax   <= '0;
            if (opcode == OP_RESTART) begin
              segment_elapsed <= '0;
              active_segment  <= '0;
              running_flag    <= 1'b1;
              for (int i = 0; i < 6; i++) tot[i] <= '0;
            end else if (opcode == OP_TICK && running_flag) begin
              segment_elapsed <= esum[32] ? 32'hFFFFFFFF : esum[31:0];
            end
          end
        end
        ST_L_SQ0, ST_L_SQ1, ST_L_SQ2: sq <= sq + sq_term;
        ST_L_ROOT: amax <= cmax;
        ST_L_TDIVW: if (ust.done) tdur <= (mspd == '0) ? '0 : ures;
        ST_L_RDIVW: if (ust.done && tspd == '0) tdur <= tdur;
        ST_T_CHECK: begin
          lane <= '0;
          if (active_segment >= eff_count) begin
            running_flag <= 1'b0;
            done_res     <= 1'b1;
            for (int i = 0; i < 6; i++) res[i] <= tot[i];
          end else if (segment_elapsed >= cur_dur) begin
            segment_elapsed <= segment_elapsed - cur_dur;
            tot[0] <= tot[0] + t_rdata[223:192];
            tot[1] <= tot[1] + t_rdata[191:160];
            tot[2] <= tot[2] + t_rdata[159:128];
            tot[3] <= tot[3] + t_rdata[127:96];
            tot[4] <= tot[4] + t_rdata[95:64];
            tot[5] <= tot[5] + t_rdata[63:32];
            active_segment <= active_segment + CW'(1);
          end
        end
        ST_T_FDIVW: begin
          if (ust.done) begin
            if (cur_dur == '0 || ures >= (96'd1 << FRAC_BITS)) begin
              frac <= 64'd1 << FRAC_BITS;
            end else begin
              frac <= ures[63:0];
            end
          end
        end
        ST_T_MUL: prod <= 64'(sprod);
        ST_T_MULW: begin
          res[lane] <= tot[lane] + shq[31:0];
          lane      <= lane + 3'd1;
        end
        ST_T_OUT: done_res <= 1'b0;
        default: ;
      endcase
    end
  end

  always_comb begin
    pos_x   = res[0];
    pos_y   = res[1];
    pos_z   = res[2];
    angle_x = res[3];
    angle_y = res[4];
    angle_z = res[5];
  end

  assign in_stall  = (state != ST_IDLE);
  assign out_valid = (state == ST_OUT);

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while a result is pending");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped while stalled");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !ust.busy)
    else $error("shared unit busy while idle");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && done_res) |-> !running_flag)
    else $error("done result while still running");
endmodule
